// ===== rtl/core/fnpc_pkg.sv =====
// types, constants and the arctangent table shared by the face planarity check
package fnpc_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int HALF_TURN_DEG   = 180;
  localparam int ANGLE_MAX       = HALF_TURN_DEG * 256;
  localparam int QUARTER_TURN_Q16 = (HALF_TURN_DEG / 2) * 65536;
  localparam int TOL_RESET       = 5120;
  localparam int ATAN_LEN        = 24;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] corner0_x;
    logic signed [COORD_WIDTH-1:0] corner0_y;
    logic signed [COORD_WIDTH-1:0] corner0_z;
    logic signed [COORD_WIDTH-1:0] corner1_x;
    logic signed [COORD_WIDTH-1:0] corner1_y;
    logic signed [COORD_WIDTH-1:0] corner1_z;
    logic signed [COORD_WIDTH-1:0] corner2_x;
    logic signed [COORD_WIDTH-1:0] corner2_y;
    logic signed [COORD_WIDTH-1:0] corner2_z;
    logic                          last_triangle;
  } fnpc_in_t;

  typedef struct packed {
    logic        is_planar;
    logic [15:0] deviation_angle;
  } fnpc_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EDGE,
    ST_ESHIFT,
    ST_XMUL,
    ST_XACC,
    ST_NORM,
    ST_SQMUL,
    ST_SQACC,
    ST_SQRT,
    ST_DINIT,
    ST_DIV,
    ST_DECIDE,
    ST_DMUL,
    ST_DACC,
    ST_CINIT,
    ST_CORDIC,
    ST_CEND,
    ST_FINISH
  } fnpc_state_e;

  // atan(2^-i) in degrees, Q.16, rounded
  function automatic logic signed [31:0] atan_q16(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/face_normal_planarity_check_core.sv =====
// face planarity check: normal deviation of each triangle against the first one of the face
//
// One triangle per transaction. The block takes a triangle only when idle and keeps the input
// stalled while it works on it: every product goes through one 32x32 multiplier and one
// 64-bit accumulator, the normal is scaled by a one-bit-per-cycle shifter, the lengths come
// from a bit-serial square root, the unit normal from a restoring divider and the angle from
// a CORDIC. The angle is computed only for a later triangle of a face and is skipped when
// the face has already failed or either normal is zero; a triangle with a zero normal also
// skips the square root and the divider. The result transaction appears only for the
// triangle marked last; a held result does not block the next triangle until that triangle
// is itself the last one.
module face_normal_planarity_check_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fnpc_pkg::fnpc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fnpc_pkg::fnpc_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i
);

  fnpc_pkg::fnpc_state_e state_q, state_d;
  logic                  phase_q, phase_d;
  logic                  have_ref_q, have_ref_d;
  logic                  failed_q, failed_d;
  logic [15:0]           fail_ang_q, fail_ang_d;
  logic signed [15:0]    ref_q [3];
  logic signed [15:0]    ref_d [3];
  logic [15:0]           tol_q, tol_d;
  logic                  out_valid_q, out_valid_d;
  logic [4:0]            step_q, step_d;

  fnpc_pkg::fnpc_in_t    in_q, in_d;
  fnpc_pkg::fnpc_out_t   out_data_q, out_data_d;
  logic signed [32:0]    e_q [6];
  logic signed [32:0]    e_d [6];
  logic signed [63:0]    prod_q, prod_d;
  logic signed [63:0]    acc_q, acc_d;
  logic [61:0]           cm_q [3];
  logic [61:0]           cm_d [3];
  logic                  cs_q [3];
  logic                  cs_d [3];
  logic [3:0]            bit_q, bit_d;
  logic [63:0]           sq_v_q, sq_v_d;
  logic [63:0]           sq_r_q, sq_r_d;
  logic [14:0]           num_lo_q, num_lo_d;
  logic [31:0]           rem_q, rem_d;
  logic [14:0]           quot_q, quot_d;
  logic signed [15:0]    n_q [3];
  logic signed [15:0]    n_d [3];
  logic signed [31:0]    dot_q, dot_d;
  logic signed [39:0]    cx_q, cx_d;
  logic signed [39:0]    cy_q, cy_d;
  logic signed [31:0]    cacc_q, cacc_d;

  logic signed [31:0]    mul_a, mul_b;
  logic signed [63:0]    mul_p;
  logic signed [31:0]    uvec [3];
  logic signed [31:0]    vvec [3];
  logic signed [63:0]    acc_n;
  logic [63:0]           cmag;
  logic [32:0]           emag;
  logic                  e_big;
  logic                  c_zero, c_hi, c_lo;
  logic                  ref_zero, n_zero;
  logic [5:0]            sq_sh;
  logic [63:0]           sq_b, sq_t;
  logic [44:0]           num_n;
  logic [31:0]           div_t;
  logic                  div_ge;
  logic [14:0]           q_fin;
  logic signed [39:0]    xs, ys;
  logic signed [31:0]    ang32;
  logic [15:0]           ang16;
  logic [31:0]           norm;

  function automatic logic signed [32:0] shr1_trunc(input logic signed [32:0] v);
    logic signed [32:0] r;
    if (v[32]) begin
      r = -((-v) >>> 1);
    end else begin
      r = v >>> 1;
    end
    return r;
  endfunction

  assign mul_p       = mul_a * mul_b;
  assign in_stall_o  = (state_q != fnpc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      uvec[k] = phase_q ? {{16{ref_q[k][15]}}, ref_q[k]} : e_q[k][31:0];
      vvec[k] = phase_q ? {{16{n_q[k][15]}}, n_q[k]} : e_q[k+3][31:0];
    end
    e_big = 1'b0;
    for (int k = 0; k < 6; k++) begin
      emag = e_q[k][32] ? 33'(-e_q[k]) : 33'(e_q[k]);
      if (emag[32:30] != 3'd0) begin
        e_big = 1'b1;
      end
    end
    c_zero   = 1'b1;
    c_hi     = 1'b0;
    c_lo     = 1'b1;
    ref_zero = 1'b1;
    n_zero   = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (cm_q[k] != '0) c_zero = 1'b0;
      if (cm_q[k][61:30] != '0) c_hi = 1'b1;
      if (cm_q[k][61:29] != '0) c_lo = 1'b0;
      if (ref_q[k] != '0) ref_zero = 1'b0;
      if (n_q[k] != '0) n_zero = 1'b0;
    end
    acc_n  = (state_q == fnpc_pkg::ST_XACC && step_q[0]) ? acc_q - prod_q : acc_q + prod_q;
    cmag   = acc_n[63] ? 64'(-acc_n) : 64'(acc_n);
    sq_sh  = 6'd62 - {step_q, 1'b0};
    sq_b   = 64'd1 << sq_sh;
    sq_t   = sq_r_q + sq_b;
    num_n  = {1'b0, cm_q[step_q[1:0]][29:0], 14'd0} + {14'd0, sq_r_q[31:1]};
    div_t  = {rem_q[30:0], num_lo_q[4'd14 - bit_q]};
    div_ge = (div_t >= sq_r_q[31:0]);
    q_fin  = {quot_q[13:0], div_ge};
    xs     = cx_q >>> step_q;
    ys     = cy_q >>> step_q;
    ang32  = (cacc_q + 32'sd128) >>> 8;
    if (ang32[31]) begin
      ang16 = 16'd0;
    end else if (ang32 > 32'(fnpc_pkg::ANGLE_MAX)) begin
      ang16 = 16'(fnpc_pkg::ANGLE_MAX);
    end else begin
      ang16 = ang32[15:0];
    end
    norm = sq_r_q[31:0];
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    have_ref_d  = have_ref_q;
    failed_d    = failed_q;
    fail_ang_d  = fail_ang_q;
    ref_d       = ref_q;
    tol_d       = tol_q;
    out_valid_d = out_valid_q;
    step_d      = step_q;
    in_d        = in_q;
    out_data_d  = out_data_q;
    e_d         = e_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    cm_d        = cm_q;
    cs_d        = cs_q;
    bit_d       = bit_q;
    sq_v_d      = sq_v_q;
    sq_r_d      = sq_r_q;
    num_lo_d    = num_lo_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    n_d         = n_q;
    dot_d       = dot_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cacc_d      = cacc_q;
    mul_a       = '0;
    mul_b       = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_we_i) begin
      tol_d = cfg_wdata_i;
    end

    case (state_q)
      fnpc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          in_d    = in_data_i;
          phase_d = 1'b0;
          state_d = fnpc_pkg::ST_EDGE;
        end
      end
      fnpc_pkg::ST_EDGE: begin
        e_d[0] = {in_q.corner1_x[31], in_q.corner1_x} - {in_q.corner0_x[31], in_q.corner0_x};
        e_d[1] = {in_q.corner1_y[31], in_q.corner1_y} - {in_q.corner0_y[31], in_q.corner0_y};
        e_d[2] = {in_q.corner1_z[31], in_q.corner1_z} - {in_q.corner0_z[31], in_q.corner0_z};
        e_d[3] = {in_q.corner2_x[31], in_q.corner2_x} - {in_q.corner0_x[31], in_q.corner0_x};
        e_d[4] = {in_q.corner2_y[31], in_q.corner2_y} - {in_q.corner0_y[31], in_q.corner0_y};
        e_d[5] = {in_q.corner2_z[31], in_q.corner2_z} - {in_q.corner0_z[31], in_q.corner0_z};
        state_d = fnpc_pkg::ST_ESHIFT;
      end
      fnpc_pkg::ST_ESHIFT: begin
        if (e_big) begin
          for (int k = 0; k < 6; k++) begin
            e_d[k] = shr1_trunc(e_q[k]);
          end
        end else begin
          step_d  = '0;
          acc_d   = '0;
          state_d = fnpc_pkg::ST_XMUL;
        end
      end
      fnpc_pkg::ST_XMUL: begin
        case (step_q[2:0])
          3'd0: begin mul_a = uvec[1]; mul_b = vvec[2]; end
          3'd1: begin mul_a = uvec[2]; mul_b = vvec[1]; end
          3'd2: begin mul_a = uvec[2]; mul_b = vvec[0]; end
          3'd3: begin mul_a = uvec[0]; mul_b = vvec[2]; end
          3'd4: begin mul_a = uvec[0]; mul_b = vvec[1]; end
          default: begin mul_a = uvec[1]; mul_b = vvec[0]; end
        endcase
        prod_d  = mul_p;
        state_d = fnpc_pkg::ST_XACC;
      end
      fnpc_pkg::ST_XACC: begin
        if (step_q[0]) begin
          cm_d[step_q[2:1]] = cmag[61:0];
          cs_d[step_q[2:1]] = acc_n[63];
          acc_d             = '0;
        end else begin
          acc_d = acc_n;
        end
        if (step_q == 5'd5) begin
          step_d = '0;
          if (phase_q) begin
            state_d = fnpc_pkg::ST_DMUL;
          end else begin
            state_d = fnpc_pkg::ST_NORM;
          end
        end else begin
          step_d  = step_q + 5'd1;
          state_d = fnpc_pkg::ST_XMUL;
        end
      end
      fnpc_pkg::ST_NORM: begin
        if (c_zero) begin
          for (int k = 0; k < 3; k++) begin
            n_d[k] = '0;
          end
          state_d = fnpc_pkg::ST_DECIDE;
        end else if (c_hi) begin
          for (int k = 0; k < 3; k++) begin
            cm_d[k] = cm_q[k] >> 1;
          end
        end else if (c_lo) begin
          for (int k = 0; k < 3; k++) begin
            cm_d[k] = cm_q[k] << 1;
          end
        end else begin
          step_d  = '0;
          acc_d   = '0;
          state_d = fnpc_pkg::ST_SQMUL;
        end
      end
      fnpc_pkg::ST_SQMUL: begin
        mul_a   = {2'b00, cm_q[step_q[1:0]][29:0]};
        mul_b   = {2'b00, cm_q[step_q[1:0]][29:0]};
        prod_d  = mul_p;
        state_d = fnpc_pkg::ST_SQACC;
      end
      fnpc_pkg::ST_SQACC: begin
        if (step_q == 5'd2) begin
          sq_v_d  = acc_n;
          sq_r_d  = '0;
          step_d  = '0;
          state_d = fnpc_pkg::ST_SQRT;
        end else begin
          acc_d   = acc_n;
          step_d  = step_q + 5'd1;
          state_d = fnpc_pkg::ST_SQMUL;
        end
      end
      fnpc_pkg::ST_SQRT: begin
        if (sq_v_q >= sq_t) begin
          sq_v_d = sq_v_q - sq_t;
          sq_r_d = (sq_r_q >> 1) + sq_b;
        end else begin
          sq_r_d = sq_r_q >> 1;
        end
        if (step_q == 5'd31) begin
          step_d = '0;
          if (phase_q) begin
            state_d = fnpc_pkg::ST_CINIT;
          end else begin
            state_d = fnpc_pkg::ST_DINIT;
          end
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      fnpc_pkg::ST_DINIT: begin
        num_lo_d = num_n[14:0];
        rem_d    = {2'b00, num_n[44:15]};
        quot_d   = '0;
        bit_d    = '0;
        state_d  = fnpc_pkg::ST_DIV;
      end
      fnpc_pkg::ST_DIV: begin
        rem_d  = div_ge ? div_t - sq_r_q[31:0] : div_t;
        quot_d = q_fin;
        if (bit_q == 4'd14) begin
          n_d[step_q[1:0]] = cs_q[step_q[1:0]] ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
          if (step_q == 5'd2) begin
            state_d = fnpc_pkg::ST_DECIDE;
          end else begin
            step_d  = step_q + 5'd1;
            state_d = fnpc_pkg::ST_DINIT;
          end
        end else begin
          bit_d = bit_q + 4'd1;
        end
      end
      fnpc_pkg::ST_DECIDE: begin
        if (!have_ref_q) begin
          ref_d      = n_q;
          have_ref_d = 1'b1;
          state_d    = fnpc_pkg::ST_FINISH;
        end else if (failed_q || ref_zero || n_zero) begin
          state_d = fnpc_pkg::ST_FINISH;
        end else begin
          phase_d = 1'b1;
          step_d  = '0;
          acc_d   = '0;
          state_d = fnpc_pkg::ST_XMUL;
        end
      end
      fnpc_pkg::ST_DMUL: begin
        mul_a   = uvec[step_q[1:0]];
        mul_b   = vvec[step_q[1:0]];
        prod_d  = mul_p;
        state_d = fnpc_pkg::ST_DACC;
      end
      fnpc_pkg::ST_DACC: begin
        if (step_q == 5'd2) begin
          dot_d   = acc_n[31:0];
          step_d  = '0;
          acc_d   = '0;
          state_d = fnpc_pkg::ST_SQMUL;
        end else begin
          acc_d   = acc_n;
          step_d  = step_q + 5'd1;
          state_d = fnpc_pkg::ST_DMUL;
        end
      end
      fnpc_pkg::ST_CINIT: begin
        step_d = '0;
        if (norm == '0 && dot_q == '0) begin
          state_d = fnpc_pkg::ST_FINISH;
        end else begin
          if (dot_q[31]) begin
            cx_d   = {8'd0, norm};
            cy_d   = -{{8{dot_q[31]}}, dot_q};
            cacc_d = 32'(fnpc_pkg::QUARTER_TURN_Q16);
          end else begin
            cx_d   = {{8{dot_q[31]}}, dot_q};
            cy_d   = {8'd0, norm};
            cacc_d = '0;
          end
          state_d = fnpc_pkg::ST_CORDIC;
        end
      end
      fnpc_pkg::ST_CORDIC: begin
        if (!cy_q[39]) begin
          cx_d   = cx_q + ys;
          cy_d   = cy_q - xs;
          cacc_d = cacc_q + fnpc_pkg::atan_q16(step_q);
        end else begin
          cx_d   = cx_q - ys;
          cy_d   = cy_q + xs;
          cacc_d = cacc_q - fnpc_pkg::atan_q16(step_q);
        end
        if (step_q == 5'(CORDIC_STEPS - 1)) begin
          state_d = fnpc_pkg::ST_CEND;
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      fnpc_pkg::ST_CEND: begin
        if (ang16 > tol_q) begin
          failed_d   = 1'b1;
          fail_ang_d = ang16;
        end
        state_d = fnpc_pkg::ST_FINISH;
      end
      fnpc_pkg::ST_FINISH: begin
        if (!in_q.last_triangle) begin
          state_d = fnpc_pkg::ST_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          out_valid_d                = 1'b1;
          out_data_d.is_planar       = ~failed_q;
          out_data_d.deviation_angle = failed_q ? fail_ang_q : 16'd0;
          have_ref_d                 = 1'b0;
          failed_d                   = 1'b0;
          fail_ang_d                 = '0;
          for (int k = 0; k < 3; k++) begin
            ref_d[k] = '0;
          end
          state_d = fnpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fnpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fnpc_pkg::ST_IDLE;
      phase_q     <= 1'b0;
      have_ref_q  <= 1'b0;
      failed_q    <= 1'b0;
      fail_ang_q  <= '0;
      tol_q       <= 16'(fnpc_pkg::TOL_RESET);
      out_valid_q <= 1'b0;
      step_q      <= '0;
      for (int k = 0; k < 3; k++) begin
        ref_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      have_ref_q  <= have_ref_d;
      failed_q    <= failed_d;
      fail_ang_q  <= fail_ang_d;
      tol_q       <= tol_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      ref_q       <= ref_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q       <= in_d;
    out_data_q <= out_data_d;
    e_q        <= e_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    cm_q       <= cm_d;
    cs_q       <= cs_d;
    bit_q      <= bit_d;
    sq_v_q     <= sq_v_d;
    sq_r_q     <= sq_r_d;
    num_lo_q   <= num_lo_d;
    rem_q      <= rem_d;
    quot_q     <= quot_d;
    n_q        <= n_d;
    dot_q      <= dot_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    cacc_q     <= cacc_d;
  end

endmodule
